// ----- hw/rtl/stlex_pkg.sv -----
// Shared types, codes and byte-class functions for the token lexer.
// No dependencies; every other file imports this package.
package stlex_pkg;

    localparam int MAX_TEXT_DEF   = 65535;
    localparam int MAX_TOKENS_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;
    localparam int SLOTS          = 3;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_DIGITS = 2'd1,
        MODE_IDENT  = 2'd2,
        MODE_ERROR  = 2'd3
    } lex_mode_t;

    typedef enum logic [2:0] {
        KIND_OPEN   = 3'd0,
        KIND_CLOSE  = 3'd1,
        KIND_NUMBER = 3'd2,
        KIND_IDENT  = 3'd3,
        KIND_END    = 3'd4,
        KIND_ERROR  = 3'd5
    } lex_kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       text_end;
    } lex_in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] token_len;
        logic [12:0] token_total;
        logic        final_res;
    } lex_out_t;

    // results caused by one input item, slot 0 first
    typedef struct packed {
        lex_out_t [SLOTS-1:0] slot;
        logic [1:0]           last_idx;
    } lex_bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        logic sym;
        case (c)
            "!", "$", "%", "&", "*", "/", ":", "<", "=", ">",
            "?", "@", "^", "~", "_": sym = 1'b1;
            default:                 sym = 1'b0;
        endcase
        return sym || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_ident_more(input logic [7:0] c);
        return is_ident_start(c) || is_digit(c) || (c == "+") || (c == "-") || (c == ".");
    endfunction

endpackage

// ----- hw/rtl/stlex_front.sv -----
// Front end: classifies each byte, keeps lexer mode and position, and
// builds the bundle of results it causes. Depends on stlex_pkg.
module stlex_front #(
    parameter int MAX_TEXT   = stlex_pkg::MAX_TEXT_DEF,
    parameter int MAX_TOKENS = stlex_pkg::MAX_TOKENS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  stlex_pkg::lex_in_t    byte_item,
    input  logic                  q_full,
    output logic                  push,
    output stlex_pkg::lex_bundle_t bundle
);
    import stlex_pkg::*;

    localparam logic [15:0] TEXT_LIM  = 16'(MAX_TEXT);
    localparam logic [12:0] COUNT_CAP = 13'((MAX_TOKENS > 8191) ? 8191 : MAX_TOKENS);

    lex_mode_t   mode_reg, mode_next, mid_mode;
    logic [15:0] pos_reg, pos_next, mid_pos;
    logic [15:0] start_reg, start_next, mid_start;
    logic [12:0] count_reg, count_next;

    logic        fire, is_zero, at_limit, cont, live, pending;
    logic        flush_a, flush_b, own_emit, end_now;
    lex_kind_t   own_kind;
    logic [15:0] own_len;
    logic [1:0]  n;
    logic [12:0] cnt;

    assign fire = byte_valid && !q_full;

    function automatic logic [12:0] sat_inc(input logic [12:0] v);
        return (v < COUNT_CAP) ? v + 13'd1 : v;
    endfunction

    // next state
    always_comb
    begin
        is_zero   = (byte_item.ch == 8'd0);
        at_limit  = (pos_reg >= TEXT_LIM);
        cont      = !at_limit &&
                    (((mode_reg == MODE_DIGITS) && is_digit(byte_item.ch)) ||
                     ((mode_reg == MODE_IDENT) && is_ident_more(byte_item.ch)));
        live      = !is_zero && (mode_reg != MODE_ERROR);
        pending   = (mode_reg == MODE_DIGITS) || (mode_reg == MODE_IDENT);
        flush_a   = pending && (is_zero || !cont);
        own_emit  = 1'b0;
        own_kind  = KIND_ERROR;
        own_len   = 16'd0;
        mid_mode  = mode_reg;
        mid_start = start_reg;
        if (is_zero)
        begin
            mid_mode = MODE_IDLE;
        end
        else if (live && !cont)
        begin
            mid_mode = MODE_IDLE;
            if (at_limit)
            begin
                own_emit = 1'b1;
                mid_mode = MODE_ERROR;
            end
            else if ((byte_item.ch == " ") || (byte_item.ch == "\n"))
            begin
                own_emit = 1'b0;
            end
            else if ((byte_item.ch == "(") || (byte_item.ch == "["))
            begin
                own_emit = 1'b1;
                own_kind = KIND_OPEN;
                own_len  = 16'd1;
            end
            else if ((byte_item.ch == ")") || (byte_item.ch == "]"))
            begin
                own_emit = 1'b1;
                own_kind = KIND_CLOSE;
                own_len  = 16'd1;
            end
            else if (is_digit(byte_item.ch))
            begin
                mid_mode  = MODE_DIGITS;
                mid_start = pos_reg;
            end
            else if (is_ident_start(byte_item.ch))
            begin
                mid_mode  = MODE_IDENT;
                mid_start = pos_reg;
            end
            else if ((byte_item.ch == "+") || (byte_item.ch == "-"))
            begin
                own_emit = 1'b1;
                own_kind = KIND_IDENT;
                own_len  = 16'd1;
            end
            else
            begin
                own_emit = 1'b1;
                mid_mode = MODE_ERROR;
            end
        end
        mid_pos    = (live && (mid_mode != MODE_ERROR)) ? pos_reg + 16'd1 : pos_reg;
        end_now    = is_zero || byte_item.text_end;
        flush_b    = end_now && ((mid_mode == MODE_DIGITS) || (mid_mode == MODE_IDENT));
        mode_next  = end_now ? MODE_IDLE : mid_mode;
        pos_next   = end_now ? 16'd0 : mid_pos;
        start_next = end_now ? 16'd0 : mid_start;
    end

    // results
    always_comb
    begin
        n          = 2'd0;
        cnt        = count_reg;
        bundle     = '0;
        if (flush_a)
        begin
            cnt = sat_inc(cnt);
            bundle.slot[n] = '{(mode_reg == MODE_DIGITS) ? KIND_NUMBER : KIND_IDENT,
                               start_reg, pos_reg - start_reg, cnt, 1'b0};
            n = n + 2'd1;
        end
        if (own_emit)
        begin
            if (own_kind != KIND_ERROR)
                cnt = sat_inc(cnt);
            bundle.slot[n] = '{own_kind, pos_reg, own_len, cnt, 1'b0};
            n = n + 2'd1;
        end
        if (flush_b)
        begin
            cnt = sat_inc(cnt);
            bundle.slot[n] = '{(mid_mode == MODE_DIGITS) ? KIND_NUMBER : KIND_IDENT,
                               mid_start, mid_pos - mid_start, cnt, 1'b0};
            n = n + 2'd1;
        end
        if (end_now)
        begin
            bundle.slot[n] = '{KIND_END, mid_pos, 16'd0, cnt, 1'b1};
            n = n + 2'd1;
        end
        bundle.last_idx = n - 2'd1;
        push            = fire && (n != 2'd0);
        count_next      = end_now ? 13'd0 : cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= 16'd0;
            start_reg <= 16'd0;
            count_reg <= 13'd0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/stlex_queue.sv -----
// Short queue of result bundles between front and back ends.
// Depends on stlex_pkg.
module stlex_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  stlex_pkg::lex_bundle_t wr_data,
    input  logic                   pop,
    output logic                   full,
    output logic                   nonempty,
    output stlex_pkg::lex_bundle_t rd_data
);
    import stlex_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    lex_bundle_t   mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/stlex_emit.sv -----
// Back end: holds one bundle and sends its results one item per cycle while tok_stall is low.
// Depends on stlex_pkg.
module stlex_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_nonempty,
    input  stlex_pkg::lex_bundle_t q_data,
    output logic                   pop,
    output logic                   tok_valid,
    input  logic                   tok_stall,
    output stlex_pkg::lex_out_t    tok_item
);
    import stlex_pkg::*;

    lex_bundle_t cur_reg;
    logic [1:0]  idx_reg;
    logic        valid_reg;
    logic        take, done;

    assign tok_valid = valid_reg;
    assign tok_item  = cur_reg.slot[idx_reg];
    assign take      = valid_reg && !tok_stall;
    assign done      = take && (idx_reg == cur_reg.last_idx);
    assign pop       = q_nonempty && (!valid_reg || done);

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ----- hw/rtl/scheme_token_lexer_unit.sv -----
// Top level of the token lexer: front end, bundle queue and back end.
// Depends on stlex_pkg, stlex_front, stlex_queue and stlex_emit.
//
// Takes one byte of text per cycle while the queue has room and reports
// brackets, numbers, identifiers, errors and an end-of-text count. A byte is
// classified combinationally and causes zero to three results, which go into
// a four-entry queue as one bundle; the back end sends them one per cycle,
// while tok_stall is low, from its output register; a byte's results pass
// through the queue and then that register. Bytes are taken every cycle
// while the queue has room; the single output port sets the rate.
module scheme_token_lexer_unit #(
    parameter int MAX_TEXT   = stlex_pkg::MAX_TEXT_DEF,
    parameter int MAX_TOKENS = stlex_pkg::MAX_TOKENS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  stlex_pkg::lex_in_t  byte_item,
    output logic                tok_valid,
    input  logic                tok_stall,
    output stlex_pkg::lex_out_t tok_item
);
    import stlex_pkg::*;

    lex_bundle_t f_bundle, q_data;
    logic        push, pop, q_full, q_nonempty;

    assign byte_stall = q_full;

    stlex_front #(
        .MAX_TEXT   (MAX_TEXT),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .push       (push),
        .bundle     (f_bundle)
    );

    stlex_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (f_bundle),
        .pop      (pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .rd_data  (q_data)
    );

    stlex_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

endmodule
